### hw/rtl/ptvn_pkg.sv
// Package: shared types and constants of the three-vector normalizer.
`default_nettype none
package ptvn_pkg;
    localparam int FRAC_BITS = 28;
    localparam int NST       = FRAC_BITS + 1;
    localparam int WQ        = FRAC_BITS + 1;
    localparam int WP        = FRAC_BITS + 67;
    localparam int WR        = 2 * FRAC_BITS + 70;
    localparam int Q_DEPTH   = 4;
    localparam int QAW       = $clog2(Q_DEPTH);
    localparam int LAT       = NST + 4;

    typedef struct packed {
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic               pinned;
        logic               last_in;
    } t_in_req;

    typedef struct packed {
        logic signed [31:0] unit_x;
        logic signed [31:0] unit_y;
        logic signed [31:0] unit_z;
        logic               last_out;
    } t_out_res;

    typedef struct packed {
        logic [2:0][31:0] comp;
        logic [2:0][63:0] msq;
        logic [63:0]      sum;
        logic             pass;
        logic             last;
    } t_job;

    typedef struct packed {
        logic empty;
        logic almost_full;
    } t_q_stat;
endpackage
`default_nettype wire

### hw/rtl/ptvn_front.sv
// Front end: accept requests, square components, sum and classify.
`default_nettype none
module ptvn_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_acc,
    input  wire ptvn_pkg::t_in_req i_req,
    output logic                  o_push,
    output ptvn_pkg::t_job        o_job
);
    import ptvn_pkg::*;

    logic             r_s1_vld;
    t_in_req          r_s1_req;
    logic [2:0][63:0] r_s1_sq;
    logic             r_s2_vld;
    t_job             r_s2_job;
    logic [2:0][31:0] w_comp;
    logic [2:0][31:0] w_mag;
    logic [63:0]      w_sum;

    always_comb begin
        w_comp[0] = i_req.vec_x;
        w_comp[1] = i_req.vec_y;
        w_comp[2] = i_req.vec_z;
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = w_comp[i][31] ? (32'd0 - w_comp[i]) : w_comp[i];
        end
        w_sum = r_s1_sq[0] + r_s1_sq[1] + r_s1_sq[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_acc;
            r_s2_vld <= r_s1_vld;
        end
        r_s1_req <= i_req;
        for (int i = 0; i < 3; i++) begin
            r_s1_sq[i] <= 64'(w_mag[i]) * 64'(w_mag[i]);
        end
        r_s2_job.comp[0] <= r_s1_req.vec_x;
        r_s2_job.comp[1] <= r_s1_req.vec_y;
        r_s2_job.comp[2] <= r_s1_req.vec_z;
        r_s2_job.msq     <= r_s1_sq;
        r_s2_job.sum     <= w_sum;
        r_s2_job.pass    <= r_s1_req.pinned || (w_sum == 64'd0);
        r_s2_job.last    <= r_s1_req.last_in;
    end

    assign o_push = r_s2_vld;
    assign o_job  = r_s2_job;
endmodule
`default_nettype wire

### hw/rtl/ptvn_queue.sv
// Short queue between the front end and the back end.
`default_nettype none
module ptvn_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire ptvn_pkg::t_job i_job,
    input  wire logic           i_pop,
    output ptvn_pkg::t_job      o_job,
    output ptvn_pkg::t_q_stat   o_stat
);
    import ptvn_pkg::*;

    t_job           r_mem [Q_DEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QAW:0]   r_cnt;
    logic           w_pop;

    assign w_pop = i_pop && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (w_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QAW+1)'(i_push) - (QAW+1)'(w_pop);
        end
        if (i_push) r_mem[r_wp] <= i_job;
    end

    assign o_job              = r_mem[r_rp];
    assign o_stat.empty       = (r_cnt == '0);
    assign o_stat.almost_full = (r_cnt >= (QAW+1)'(Q_DEPTH - 2));
endmodule
`default_nettype wire

### hw/rtl/ptvn_back.sv
// Back end: pipelined digit search of each rounded unit component.
`default_nettype none
module ptvn_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_vld,
    input  wire ptvn_pkg::t_job   i_job,
    output logic                  o_strobe,
    output ptvn_pkg::t_out_res    o_res
);
    import ptvn_pkg::*;

    logic                          r_vld [NST+1];
    t_job                          r_job [NST+1];
    logic signed [2:0][WR-1:0]     r_r   [NST+1];
    logic signed [2:0][WP-1:0]     r_p   [NST+1];
    logic [2:0][WQ-1:0]            r_q   [NST+1];
    logic [2:0][31:0]              w_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld[0] <= 1'b0;
        else r_vld[0] <= i_vld;
        r_job[0] <= i_job;
        for (int i = 0; i < 3; i++) begin
            r_r[0][i] <= (WR'(i_job.msq[i]) << (2 * FRAC_BITS + 2)) - WR'(i_job.sum);
            r_p[0][i] <= WP'(0) - WP'(i_job.sum);
            r_q[0][i] <= '0;
        end
    end

    for (genvar k = 0; k < NST; k++) begin : g_stage
        localparam int B = FRAC_BITS - k;
        logic [2:0][WR-1:0] w_t;
        logic [2:0][WR-1:0] w_pe;

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                w_pe[i] = {{(WR-WP){r_p[k][i][WP-1]}}, r_p[k][i]};
                w_t[i]  = r_r[k][i] - (w_pe[i] << (B + 2))
                          - (WR'(r_job[k].sum) << (2 * B + 2));
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_vld[k+1] <= 1'b0;
            else r_vld[k+1] <= r_vld[k];
            r_job[k+1] <= r_job[k];
            for (int i = 0; i < 3; i++) begin
                if (!w_t[i][WR-1]) begin
                    r_r[k+1][i] <= w_t[i];
                    r_p[k+1][i] <= r_p[k][i] + (WP'(r_job[k].sum) << (B + 1));
                    r_q[k+1][i] <= r_q[k][i] | (WQ'(1) << B);
                end else begin
                    r_r[k+1][i] <= r_r[k][i];
                    r_p[k+1][i] <= r_p[k][i];
                    r_q[k+1][i] <= r_q[k][i];
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_job[NST].pass) w_out[i] = r_job[NST].comp[i];
            else if (r_job[NST].comp[i][31]) w_out[i] = 32'd0 - 32'(r_q[NST][i]);
            else w_out[i] = 32'(r_q[NST][i]);
        end
    end

    assign o_strobe       = r_vld[NST];
    assign o_res.unit_x   = w_out[0];
    assign o_res.unit_y   = w_out[1];
    assign o_res.unit_z   = w_out[2];
    assign o_res.last_out = r_job[NST].last;
endmodule
`default_nettype wire

### hw/rtl/pinned_three_vector_normaliser_core.sv
// Top level: pinned three-vector normalizer, front end, queue and back end.
//  channel  | handshake          | payload
//  request  | i_start / o_busy   | i_req (t_in_req)
//  result   | o_strobe           | o_res (t_out_res)
// One request per cycle while o_busy is low; each result passes through the front end,
// the queue and the FRAC_BITS+1 stage digit search in the back end.
// Synchronous active-low reset empties all stages and the queue.
// The result side cannot stall; the back end drains the queue every cycle.
`default_nettype none
module pinned_three_vector_normaliser_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    output logic                   o_busy,
    input  wire ptvn_pkg::t_in_req i_req,
    output logic                   o_strobe,
    output ptvn_pkg::t_out_res     o_res
);
    import ptvn_pkg::*;

    logic    w_acc;
    logic    w_push;
    t_job    w_fjob;
    t_job    w_qjob;
    t_q_stat w_stat;

    assign o_busy = w_stat.almost_full;
    assign w_acc  = i_start && !o_busy;

    ptvn_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_acc(w_acc), .i_req(i_req),
        .o_push(w_push), .o_job(w_fjob)
    );

    ptvn_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_push), .i_job(w_fjob),
        .i_pop(1'b1), .o_job(w_qjob), .o_stat(w_stat)
    );

    ptvn_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(!w_stat.empty), .i_job(w_qjob),
        .o_strobe(o_strobe), .o_res(o_res)
    );

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !o_busy)
        else $error("busy raised");
    a_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |-> ##(LAT) o_strobe) else $error("result missing");
    a_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(w_acc, LAT)) else $error("result without request");
endmodule
`default_nettype wire
